// File: rtl/pli_pkg.sv
// Shared types, widths and constants of the PID controller with leaky integrator.
// Used by the register file, controller, datapath and top level; depends on nothing.
`default_nettype none

package pli_pkg;

   // Field widths of the configuration registers.
   localparam int GAIN_W    = 24;
   localparam int LEAK_W    = 16;
   localparam int STEP_T_W  = 24;
   localparam int RATE_W    = 16;
   localparam int ILIM_W    = 20;
   localparam int OLIM_W    = 15;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Reset values of the configuration registers.
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = 24'd78643;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = 24'd3932160;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST   = 24'd3277;
   localparam logic [LEAK_W-1:0]   LEAK_FACTOR_RST  = 16'd64553;
   localparam logic [STEP_T_W-1:0] STEP_TIME_RST    = 24'd33554;
   localparam logic [RATE_W-1:0]   STEP_RATE_RST    = 16'd500;
   localparam logic [ILIM_W-1:0]   INTEG_LIMIT_RST  = 20'd1000000;
   localparam logic [OLIM_W-1:0]   OUTPUT_LIMIT_RST = 15'd10000;

   // Datapath widths.
   localparam int IN_W     = 16;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int SUM_W    = 39;
   localparam int DERIV_W  = 34;
   localparam int INTEG_W  = 38;
   localparam int ACC_W    = 62;
   localparam int TOTAL_W  = 60;
   localparam int MUL_A_W  = 25;
   localparam int MUL_B_W  = 21;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int LO_W     = 20;
   localparam int FRAC_W   = 16;
   localparam int INC_SHIFT = 8;
   localparam int OUT_W    = 16;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_INTEG_GAIN   = 3'd1,
      REG_DERIV_GAIN   = 3'd2,
      REG_LEAK_FACTOR  = 3'd3,
      REG_STEP_TIME    = 3'd4,
      REG_STEP_RATE    = 3'd5,
      REG_INTEG_LIMIT  = 3'd6,
      REG_OUTPUT_LIMIT = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   prop_gain;
      logic [GAIN_W-1:0]   integ_gain;
      logic [GAIN_W-1:0]   deriv_gain;
      logic [LEAK_W-1:0]   leak_factor;
      logic [STEP_T_W-1:0] step_time;
      logic [RATE_W-1:0]   step_rate;
      logic [ILIM_W-1:0]   integ_limit;
      logic [OLIM_W-1:0]   output_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [IN_W-1:0] set_point;
      logic signed [IN_W-1:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    saturated;
   } rsp_type;

   // One code per datapath step; each multiply step names the multiply issued in that cycle.
   typedef enum logic [3:0] {
      STEP_NONE     = 4'd0,
      STEP_INC      = 4'd1,
      STEP_DER      = 4'd2,
      STEP_LEAK_LO  = 4'd3,
      STEP_LEAK_HI  = 4'd4,
      STEP_PROP     = 4'd5,
      STEP_DRV_LO   = 4'd6,
      STEP_DRV_HI   = 4'd7,
      STEP_INT_LO   = 4'd8,
      STEP_INT_HI   = 4'd9,
      STEP_INT_FIN  = 4'd10,
      STEP_SUM      = 4'd11,
      STEP_OUT      = 4'd12
   } step_type;

   typedef struct packed {
      logic     capture;
      step_type step;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/pid_leaky_integrator_core.sv
// Top level of the PID controller with a leaky integrator.
// Depends on pli_pkg, pli_csr, pli_ctrl and pli_datapath.
//
// Usage: each word on the request channel (req_valid, req_stall, req_data) carries a
// set point and a measured value. The block answers every word with exactly one word
// on the response channel (rsp_valid, rsp_stall, rsp_data): the clamped drive and a
// flag that is set when the drive was clamped to the output limit.
// Gains, leak factor, step time, step rate and both limits sit in eight registers
// on the APB-style csr_ port, register i at byte address 4*i. Write them only while
// no word is in flight; pready is always high.
// Sequencing: after the request word is accepted, the shared 25x21 multiplier is used in
// nine consecutive steps, since the leaky sum, the derivative term and the integral
// term are each split into two partial products; the result is then summed, clamped
// and loaded into the output register. A new word is taken only once the previous one
// has left the datapath, so an update must finish before the next word is accepted.
// When the receiver stalls, the finished result waits in the output register while
// the next word is already accepted and processed; it then waits in its last step
// until the output register is free.
// Reset clears the integrator, the previous error and the response valid flag,
// and restores all registers to their default values.
`default_nettype none

module pid_leaky_integrator_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire pli_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output pli_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [pli_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pli_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pli_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   // Live configuration, read directly by the datapath.
   pli_pkg::cfg_type    cfg;
   // Step commands from the sequencer and the output register status back to it.
   pli_pkg::cmd_type    cmd;
   pli_pkg::status_type status;

   pli_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer accepts a request word only from its idle state.
   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the controller state and the output register.
   pli_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/pli_csr.sv
// Configuration register file with an APB-style access port.
// Depends on pli_pkg for register widths, reset values and indexes.
`default_nettype none

module pli_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [pli_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [pli_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [pli_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output pli_pkg::cfg_type                      cfg
);

   pli_pkg::cfg_type      cfg_ff, cfg_in;
   pli_pkg::reg_index_type idx;
   logic                  wr_en;

   assign idx        = pli_pkg::reg_index_type'(csr_paddr[pli_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            pli_pkg::REG_PROP_GAIN:    cfg_in.prop_gain    = csr_pwdata[pli_pkg::GAIN_W-1:0];
            pli_pkg::REG_INTEG_GAIN:   cfg_in.integ_gain   = csr_pwdata[pli_pkg::GAIN_W-1:0];
            pli_pkg::REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_pwdata[pli_pkg::GAIN_W-1:0];
            pli_pkg::REG_LEAK_FACTOR:  cfg_in.leak_factor  = csr_pwdata[pli_pkg::LEAK_W-1:0];
            pli_pkg::REG_STEP_TIME:    cfg_in.step_time    = csr_pwdata[pli_pkg::STEP_T_W-1:0];
            pli_pkg::REG_STEP_RATE:    cfg_in.step_rate    = csr_pwdata[pli_pkg::RATE_W-1:0];
            pli_pkg::REG_INTEG_LIMIT:  cfg_in.integ_limit  = csr_pwdata[pli_pkg::ILIM_W-1:0];
            pli_pkg::REG_OUTPUT_LIMIT: cfg_in.output_limit = csr_pwdata[pli_pkg::OLIM_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         pli_pkg::REG_PROP_GAIN:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::GAIN_W){1'b0}}, cfg_ff.prop_gain};
         pli_pkg::REG_INTEG_GAIN:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::GAIN_W){1'b0}}, cfg_ff.integ_gain};
         pli_pkg::REG_DERIV_GAIN:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::GAIN_W){1'b0}}, cfg_ff.deriv_gain};
         pli_pkg::REG_LEAK_FACTOR:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::LEAK_W){1'b0}}, cfg_ff.leak_factor};
         pli_pkg::REG_STEP_TIME:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::STEP_T_W){1'b0}}, cfg_ff.step_time};
         pli_pkg::REG_STEP_RATE:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::RATE_W){1'b0}}, cfg_ff.step_rate};
         pli_pkg::REG_INTEG_LIMIT:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::ILIM_W){1'b0}}, cfg_ff.integ_limit};
         pli_pkg::REG_OUTPUT_LIMIT:
            csr_prdata = {{(pli_pkg::CSR_DATA_W-pli_pkg::OLIM_W){1'b0}}, cfg_ff.output_limit};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= pli_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain   <= pli_pkg::INTEG_GAIN_RST;
         cfg_ff.deriv_gain   <= pli_pkg::DERIV_GAIN_RST;
         cfg_ff.leak_factor  <= pli_pkg::LEAK_FACTOR_RST;
         cfg_ff.step_time    <= pli_pkg::STEP_TIME_RST;
         cfg_ff.step_rate    <= pli_pkg::STEP_RATE_RST;
         cfg_ff.integ_limit  <= pli_pkg::INTEG_LIMIT_RST;
         cfg_ff.output_limit <= pli_pkg::OUTPUT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pli_ctrl.sv
// Sequencing state machine: steps the shared multiplier through one control update.
// Depends on pli_pkg for the command and status types.
`default_nettype none

module pli_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pli_pkg::status_type status,
   output pli_pkg::cmd_type         cmd
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_INC      = 13'b0000000000010,
      ST_DER      = 13'b0000000000100,
      ST_LEAK_LO  = 13'b0000000001000,
      ST_LEAK_HI  = 13'b0000000010000,
      ST_PROP     = 13'b0000000100000,
      ST_DRV_LO   = 13'b0000001000000,
      ST_DRV_HI   = 13'b0000010000000,
      ST_INT_LO   = 13'b0000100000000,
      ST_INT_HI   = 13'b0001000000000,
      ST_INT_FIN  = 13'b0010000000000,
      ST_SUM      = 13'b0100000000000,
      ST_OUT      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.step     = pli_pkg::STEP_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) state_in = ST_INC;
         end
         ST_INC: begin
            cmd.step = pli_pkg::STEP_INC;
            state_in = ST_DER;
         end
         ST_DER: begin
            cmd.step = pli_pkg::STEP_DER;
            state_in = ST_LEAK_LO;
         end
         ST_LEAK_LO: begin
            cmd.step = pli_pkg::STEP_LEAK_LO;
            state_in = ST_LEAK_HI;
         end
         ST_LEAK_HI: begin
            cmd.step = pli_pkg::STEP_LEAK_HI;
            state_in = ST_PROP;
         end
         ST_PROP: begin
            cmd.step = pli_pkg::STEP_PROP;
            state_in = ST_DRV_LO;
         end
         ST_DRV_LO: begin
            cmd.step = pli_pkg::STEP_DRV_LO;
            state_in = ST_DRV_HI;
         end
         ST_DRV_HI: begin
            cmd.step = pli_pkg::STEP_DRV_HI;
            state_in = ST_INT_LO;
         end
         ST_INT_LO: begin
            cmd.step = pli_pkg::STEP_INT_LO;
            state_in = ST_INT_HI;
         end
         ST_INT_HI: begin
            cmd.step = pli_pkg::STEP_INT_HI;
            state_in = ST_INT_FIN;
         end
         ST_INT_FIN: begin
            cmd.step = pli_pkg::STEP_INT_FIN;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.step = pli_pkg::STEP_SUM;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.step = pli_pkg::STEP_OUT;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result is only loaded into an output register that can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register is held");

   // Without an accepted word the sequencer stays idle.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !accept |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle without an accepted word");

   // A finished result waits while the output register is blocked.
   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !status.out_free |=> (state_ff == ST_OUT))
      else $error("finished result dropped while output was blocked");

endmodule

`default_nettype wire

// File: rtl/pli_datapath.sv
// Datapath: one shared 25x21 signed multiplier, accumulators, controller state and
// the output register. Depends on pli_pkg; driven by commands from pli_ctrl.
`default_nettype none

module pli_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pli_pkg::cfg_type  cfg,
   input  wire pli_pkg::cmd_type  cmd,
   output pli_pkg::status_type    status,
   input  wire pli_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pli_pkg::rsp_type       rsp_data
);

   localparam int ASH_W = pli_pkg::ACC_W - pli_pkg::FRAC_W;
   localparam int A_W   = pli_pkg::MUL_A_W;
   localparam int B_W   = pli_pkg::MUL_B_W;
   localparam int LO    = pli_pkg::LO_W;

   logic signed [pli_pkg::ERR_W-1:0]   err_ff, err_in, prev_ff, prev_in;
   logic signed [pli_pkg::DIFF_W-1:0]  diff;
   logic signed [pli_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic signed [pli_pkg::DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [pli_pkg::ACC_W-1:0]   acc_ff, acc_in, prod_acc;
   logic signed [pli_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [pli_pkg::TOTAL_W-1:0] total_ff, total_in, prod_tot, olim;
   logic signed [A_W-1:0]              mul_a;
   logic signed [B_W-1:0]              mul_b;
   logic signed [pli_pkg::PROD_W-1:0]  prod_ff, prod_in, prod_rnd, inc;
   logic signed [ASH_W-1:0]            acc_sh, ilim_q, ilim_neg;
   logic signed [31:0]                 t32, mag32;
   logic signed [pli_pkg::OUT_W-1:0]   mag16, lim16;
   logic                               over, under;
   logic                               rsp_valid_ff, rsp_valid_in;
   pli_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   assign diff = {err_ff[pli_pkg::ERR_W-1], err_ff} - {prev_ff[pli_pkg::ERR_W-1], prev_ff};

   assign prod_acc = {{(pli_pkg::ACC_W-pli_pkg::PROD_W){prod_ff[pli_pkg::PROD_W-1]}}, prod_ff};
   assign prod_tot = {{(pli_pkg::TOTAL_W-pli_pkg::PROD_W){prod_ff[pli_pkg::PROD_W-1]}}, prod_ff};

   // Round to nearest, ties up, before dropping the low bits of the increment.
   assign prod_rnd = prod_ff + {{(pli_pkg::PROD_W-pli_pkg::INC_SHIFT){1'b0}}, 1'b1,
                                {(pli_pkg::INC_SHIFT-1){1'b0}}};
   assign inc      = prod_rnd >>> pli_pkg::INC_SHIFT;

   assign acc_sh   = acc_ff[pli_pkg::ACC_W-1:pli_pkg::FRAC_W];
   assign ilim_q   = {{(ASH_W-pli_pkg::ILIM_W-pli_pkg::FRAC_W){1'b0}}, cfg.integ_limit,
                      {pli_pkg::FRAC_W{1'b0}}};
   assign ilim_neg = -ilim_q;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         pli_pkg::STEP_INC: begin
            mul_a = {{(A_W-pli_pkg::STEP_T_W){1'b0}}, cfg.step_time};
            mul_b = {{(B_W-pli_pkg::ERR_W){err_ff[pli_pkg::ERR_W-1]}}, err_ff};
         end
         pli_pkg::STEP_DER: begin
            mul_a = {{(A_W-pli_pkg::RATE_W){1'b0}}, cfg.step_rate};
            mul_b = {{(B_W-pli_pkg::DIFF_W){diff[pli_pkg::DIFF_W-1]}}, diff};
         end
         pli_pkg::STEP_LEAK_LO: begin
            mul_a = {{(A_W-pli_pkg::LEAK_W){1'b0}}, cfg.leak_factor};
            mul_b = {{(B_W-LO){1'b0}}, sum_ff[LO-1:0]};
         end
         pli_pkg::STEP_LEAK_HI: begin
            mul_a = {{(A_W-pli_pkg::LEAK_W){1'b0}}, cfg.leak_factor};
            mul_b = {{(B_W-pli_pkg::SUM_W+LO){sum_ff[pli_pkg::SUM_W-1]}},
                     sum_ff[pli_pkg::SUM_W-1:LO]};
         end
         pli_pkg::STEP_PROP: begin
            mul_a = {{(A_W-pli_pkg::GAIN_W){1'b0}}, cfg.prop_gain};
            mul_b = {{(B_W-pli_pkg::ERR_W){err_ff[pli_pkg::ERR_W-1]}}, err_ff};
         end
         pli_pkg::STEP_DRV_LO: begin
            mul_a = {{(A_W-pli_pkg::GAIN_W){1'b0}}, cfg.deriv_gain};
            mul_b = {{(B_W-LO){1'b0}}, deriv_ff[LO-1:0]};
         end
         pli_pkg::STEP_DRV_HI: begin
            mul_a = {{(A_W-pli_pkg::GAIN_W){1'b0}}, cfg.deriv_gain};
            mul_b = {{(B_W-pli_pkg::DERIV_W+LO){deriv_ff[pli_pkg::DERIV_W-1]}},
                     deriv_ff[pli_pkg::DERIV_W-1:LO]};
         end
         pli_pkg::STEP_INT_LO: begin
            mul_a = {{(A_W-pli_pkg::GAIN_W){1'b0}}, cfg.integ_gain};
            mul_b = {{(B_W-LO){1'b0}}, integ_ff[LO-1:0]};
         end
         pli_pkg::STEP_INT_HI: begin
            mul_a = {{(A_W-pli_pkg::GAIN_W){1'b0}}, cfg.integ_gain};
            mul_b = {{(B_W-pli_pkg::INTEG_W+LO){integ_ff[pli_pkg::INTEG_W-1]}},
                     integ_ff[pli_pkg::INTEG_W-1:LO]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Accumulation of the product issued one step earlier.
   always_comb begin
      err_in   = err_ff;
      prev_in  = prev_ff;
      sum_in   = sum_ff;
      deriv_in = deriv_ff;
      acc_in   = acc_ff;
      integ_in = integ_ff;
      total_in = total_ff;
      if (cmd.capture) begin
         err_in = {req_data.set_point[pli_pkg::IN_W-1], req_data.set_point}
                - {req_data.measured[pli_pkg::IN_W-1], req_data.measured};
      end
      case (cmd.step)
         pli_pkg::STEP_DER: begin
            sum_in = {integ_ff[pli_pkg::INTEG_W-1], integ_ff} + inc[pli_pkg::SUM_W-1:0];
         end
         pli_pkg::STEP_LEAK_LO: begin
            deriv_in = prod_ff[pli_pkg::DERIV_W-1:0];
            prev_in  = err_ff;
         end
         pli_pkg::STEP_LEAK_HI: begin
            // The rounding half is folded in here so the later shift is a plain floor.
            acc_in = prod_acc + (pli_pkg::ACC_W'(1) <<< (pli_pkg::FRAC_W - 1));
         end
         pli_pkg::STEP_PROP: begin
            acc_in = acc_ff + (prod_acc <<< LO);
         end
         pli_pkg::STEP_DRV_LO: begin
            if (acc_sh > ilim_q) begin
               integ_in = ilim_q[pli_pkg::INTEG_W-1:0];
            end else if (acc_sh < ilim_neg) begin
               integ_in = ilim_neg[pli_pkg::INTEG_W-1:0];
            end else begin
               integ_in = acc_sh[pli_pkg::INTEG_W-1:0];
            end
            total_in = prod_tot;
         end
         pli_pkg::STEP_DRV_HI: begin
            total_in = total_ff + prod_tot;
         end
         pli_pkg::STEP_INT_LO: begin
            total_in = total_ff + (prod_tot <<< LO);
         end
         pli_pkg::STEP_INT_HI: begin
            acc_in = prod_acc + (pli_pkg::ACC_W'(1) <<< (pli_pkg::FRAC_W - 1));
         end
         pli_pkg::STEP_INT_FIN: begin
            acc_in = acc_ff + (prod_acc <<< LO);
         end
         pli_pkg::STEP_SUM: begin
            total_in = total_ff + {{(pli_pkg::TOTAL_W-ASH_W){acc_sh[ASH_W-1]}}, acc_sh};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Output clamp and truncation toward zero.
   assign olim  = {{(pli_pkg::TOTAL_W-pli_pkg::OLIM_W-pli_pkg::FRAC_W){1'b0}},
                   cfg.output_limit, {pli_pkg::FRAC_W{1'b0}}};
   assign over  = total_ff > olim;
   assign under = total_ff < -olim;
   assign t32   = total_ff[31:0];
   assign mag32 = t32[31] ? -t32 : t32;
   assign mag16 = {1'b0, mag32[30:pli_pkg::FRAC_W]};
   assign lim16 = {1'b0, cfg.output_limit};

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (over) begin
         rsp_data_in.drive     = lim16;
         rsp_data_in.saturated = 1'b1;
      end else if (under) begin
         rsp_data_in.drive     = -lim16;
         rsp_data_in.saturated = 1'b1;
      end else begin
         rsp_data_in.drive     = t32[31] ? -mag16 : mag16;
         rsp_data_in.saturated = 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in    = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integ_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      sum_ff   <= sum_in;
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      prod_ff  <= prod_in;
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The integrator never leaves the widest clamp that any limit setting allows.
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= $signed({2'b00, {pli_pkg::ILIM_W{1'b1}}, {pli_pkg::FRAC_W{1'b0}}}))
      && (integ_ff >= -$signed({2'b00, {pli_pkg::ILIM_W{1'b1}}, {pli_pkg::FRAC_W{1'b0}}})))
      else $error("integrator outside its clamp range");

   // A taken result frees the output register unless a new one is loaded.
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !cmd.out_load |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

endmodule

`default_nettype wire
